// ===== design/modular_exponentiation_unit_assert.svh =====
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, switched off while arst_n is low.
`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, switched off while arst_n is low.
`define MEXP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mexp_pkg.sv =====
package mexp_pkg;

	localparam int BASE_W      = 63;
	localparam int EXP_W       = 63;
	localparam int MOD_W       = 31;
	localparam int POWER_W     = 31;
	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 32;

	localparam int EXP_BITS_DEF = 64;
	localparam int MOD_BITS_DEF = 31;

	localparam logic [MOD_W-1:0] MOD_RESET = 31'd998244353;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // take a new operand beat and start reducing the base
		logic init;      // square <= reduced base, accumulator <= 1
		logic mul;       // form both products and start both reducers
		logic update;    // take reduced products, shift the exponent
		logic emit;      // load the result register
		logic emit_zero; // result is zero rather than the accumulator
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;      // a reducer is still running
		logic sq_zero;   // reduced base is zero
		logic mod_zero;  // modulus register holds zero
	} sts_t;

endpackage

// ===== design/mexp_reducer.sv =====
module mexp_reducer #(
	parameter int MB = mexp_pkg::MOD_BITS_DEF,
	parameter int RW = 2 * mexp_pkg::MOD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RW-1:0] din,
	input  logic [MB-1:0] m,
	output logic          busy,
	output logic [MB-1:0] r
);

	localparam int STEPS = RW / 2;
	localparam int CW    = $clog2(STEPS + 1);

	logic [RW-1:0] sh_q;
	logic [MB-1:0] r_q;
	logic [CW-1:0] cnt_q;
	logic [MB-1:0] r_mid;
	logic [MB-1:0] r_nxt;

	// One restoring step: bring in the next bit, subtract the modulus once if it fits.
	function automatic logic [MB-1:0] rstep(input logic [MB-1:0] rr, input logic b,
			input logic [MB-1:0] mm);
		logic [MB:0] t;
		t = {rr, b};
		if (t >= {1'b0, mm}) begin
			t = t - {1'b0, mm};
		end
		return t[MB-1:0];
	endfunction

	always_comb begin
		r_mid = rstep(r_q, sh_q[RW-1], m);
		r_nxt = rstep(r_mid, sh_q[RW-2], m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= din;
			r_q  <= '0;
		end else if (cnt_q != '0) begin
			sh_q <= {sh_q[RW-3:0], 2'b00};
			r_q  <= r_nxt;
		end
	end

	assign busy = (cnt_q != '0);
	assign r    = r_q;

endmodule

// ===== design/mexp_datapath.sv =====
module mexp_datapath #(
	parameter int MB  = mexp_pkg::MOD_BITS_DEF,
	parameter int OPW = mexp_pkg::BASE_W,
	parameter int RW  = 2 * mexp_pkg::MOD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mexp_pkg::MOD_W-1:0]   cfg_wdata,
	input  logic [mexp_pkg::BASE_W-1:0]  base,
	input  logic [mexp_pkg::EXP_W-1:0]   exponent,
	input  mexp_pkg::cmd_t               cmd,
	output mexp_pkg::sts_t               sts,
	output logic [mexp_pkg::POWER_W-1:0] power
);

	logic [MB-1:0]   mod_q;
	logic [MB-1:0]   acc_q;
	logic [MB-1:0]   sq_q;
	logic [MB-1:0]   res_q;
	logic [OPW-1:0]  e_q;
	logic [2*MB-1:0] prod_a;
	logic [2*MB-1:0] prod_b;
	logic [RW-1:0]   din_a;
	logic [RW-1:0]   din_b;
	logic            busy_a;
	logic            busy_b;
	logic [MB-1:0]   r_a;
	logic [MB-1:0]   r_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= mexp_pkg::MOD_RESET[MB-1:0];
		end else if (cfg_we) begin
			mod_q <= cfg_wdata[MB-1:0];
		end
	end

	assign prod_a = acc_q * sq_q;
	assign prod_b = sq_q * sq_q;
	// Reducer A first reduces the base, then serves the accumulator product.
	assign din_a  = cmd.load ? RW'(base[OPW-1:0]) : RW'(prod_a);
	assign din_b  = RW'(prod_b);

	mexp_reducer #(.MB(MB), .RW(RW)) u_red_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load | cmd.mul),
		.din    (din_a),
		.m      (mod_q),
		.busy   (busy_a),
		.r      (r_a)
	);

	mexp_reducer #(.MB(MB), .RW(RW)) u_red_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul),
		.din    (din_b),
		.m      (mod_q),
		.busy   (busy_b),
		.r      (r_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q <= exponent[OPW-1:0];
		end else if (cmd.update) begin
			e_q <= e_q >> 1;
		end
		if (cmd.init) begin
			sq_q  <= r_a;
			acc_q <= MB'(1);
		end else if (cmd.update) begin
			sq_q <= r_b;
			if (e_q[0]) begin
				acc_q <= r_a;
			end
		end
		if (cmd.emit) begin
			res_q <= cmd.emit_zero ? '0 : acc_q;
		end
	end

	assign sts.busy     = busy_a | busy_b;
	assign sts.sq_zero  = (r_a == '0);
	assign sts.mod_zero = (mod_q == '0);
	assign power        = mexp_pkg::POWER_W'(res_q);

endmodule

// ===== design/mexp_ctrl.sv =====
module mexp_ctrl #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  mexp_pkg::sts_t sts,
	output mexp_pkg::cmd_t cmd
);

	localparam int BCW = $clog2(EXP_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_MUL,
		ST_RED,
		ST_FIN
	} state_t;

	state_t         state_q;
	logic [BCW-1:0] bit_q;
	logic           zero_q;
	logic           out_valid_q;
	logic           can_emit;
	logic           last_bit;

	assign can_emit = !out_valid_q || out_ready;
	assign last_bit = (bit_q == BCW'(EXP_BITS - 1));

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_BASE: cmd.init = !sts.busy;
			ST_MUL:  cmd.mul = 1'b1;
			ST_RED:  cmd.update = !sts.busy;
			ST_FIN: begin
				cmd.emit      = can_emit;
				cmd.emit_zero = zero_q;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					if (!sts.busy) begin
						bit_q <= '0;
						// A zero modulus or a base that it divides gives zero at once.
						if (sts.mod_zero || sts.sq_zero) begin
							zero_q  <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							zero_q  <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= ST_RED;
				ST_RED: begin
					if (!sts.busy) begin
						if (last_bit) begin
							state_q <= ST_FIN;
						end else begin
							bit_q   <= bit_q + 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_FIN: begin
					if (can_emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== design/modular_exponentiation_unit.sv =====
// Modular exponentiation: each input beat carries a base and an exponent, and one output
// beat returns base to the power exponent modulo the modulus register (reset 998244353),
// with zero whenever the modulus divides the base, even for a zero exponent. The exponent
// is scanned from its least significant bit, and for every bit the accumulator product and
// the square are reduced side by side in two shift-subtract reducers that retire two
// product bits a cycle, where RW = max(2*MOD_BITS, min(EXP_BITS, 63)) rounded up to even
// is the width that each reducer takes in. An item whose base the modulus divides skips the
// exponent scan. Items are handled one at a time, and the next beat is taken as soon as the
// result is in the output register. The modulus is written through cfg_we and cfg_wdata;
// the user must write it only while no item is in flight, as the block does not enforce it.
module modular_exponentiation_unit #(
	parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF,
	parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mexp_pkg::MOD_W-1:0]       cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [mexp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // base [62:0], exponent [125:63]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [mexp_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // power [30:0]
);

	localparam int OPW    = (EXP_BITS < mexp_pkg::BASE_W) ? EXP_BITS : mexp_pkg::BASE_W;
	localparam int RW_RAW = (OPW > 2 * MOD_BITS) ? OPW : 2 * MOD_BITS;
	localparam int RW     = RW_RAW + (RW_RAW % 2);

	mexp_pkg::cmd_t               cmd;
	mexp_pkg::sts_t               sts;
	logic [mexp_pkg::POWER_W-1:0] power;

	mexp_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mexp_datapath #(.MB(MOD_BITS), .OPW(OPW), .RW(RW)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.base      (s_axis_tdata[mexp_pkg::BASE_W-1:0]),
		.exponent  (s_axis_tdata[mexp_pkg::BASE_W+mexp_pkg::EXP_W-1:mexp_pkg::BASE_W]),
		.cmd       (cmd),
		.sts       (sts),
		.power     (power)
	);

	assign m_axis_tdata = mexp_pkg::OUT_TDATA_W'(power);

endmodule

// ===== design/mexp_checker.sv =====
`include "modular_exponentiation_unit_assert.svh"

module mexp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [mexp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// A result beat that is held back keeps its value.
	`MEXP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

	// Only one item is in work: after an input beat the block stops taking more.
	`MEXP_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")

	// A result never appears in the cycle right after an input beat.
	`MEXP_ASSERT_NXT(a_no_instant, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result raised straight after input beat")

	// Once a result is posted the block is free for the next item.
	`MEXP_ASSERT_IMP(a_ready_on_result, $rose(m_axis_tvalid), s_axis_tready, "block not ready when result posted")

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (.*);

// ===== dv/modular_exponentiation_unit_test.sv =====
module modular_exponentiation_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BASE_W       = mexp_pkg::BASE_W;
	localparam int EXP_W        = mexp_pkg::EXP_W;
	localparam int MOD_W        = mexp_pkg::MOD_W;
	localparam int POWER_W      = mexp_pkg::POWER_W;
	localparam int IN_TDATA_W   = mexp_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W  = mexp_pkg::OUT_TDATA_W;
	localparam int EXP_BITS_DEF = mexp_pkg::EXP_BITS_DEF;
	localparam logic [MOD_W-1:0] MOD_RESET = mexp_pkg::MOD_RESET;

	localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
	localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};
	localparam logic [MOD_W-1:0]  MOD_MAX  = {MOD_W{1'b1}};
	// Comfortably longer than the short path taken when the modulus divides the base.
	localparam int SETTLE_CYCLES = 100;
	localparam int SINK_HOLD_CYCLES = 8000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [MOD_W-1:0]       cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // base [62:0], exponent [125:63]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // power [30:0]

	logic [POWER_W-1:0] expected_power[$];
	logic [MOD_W-1:0]   current_modulus = MOD_RESET;
	bit                 idle_enable = 1'b1;
	int unsigned        sink_hold_cycles = 0;
	int                 mismatch_count = 0;
	int                 items_sent = 0;
	int                 results_checked = 0;
	int                 modulus_settings = 1;

	modular_exponentiation_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Right-to-left square and multiply over every exponent bit the block scans.
	function automatic logic [POWER_W-1:0] predict_power(input logic [BASE_W-1:0] base,
			input logic [EXP_W-1:0] exponent, input logic [MOD_W-1:0] modulus);
		longint unsigned m, sq, acc, e;
		m = modulus;
		e = exponent;
		if (m == 0) begin
			return '0;
		end
		sq = base % m;
		if (sq == 0) begin
			return '0;
		end
		acc = 1 % m;
		for (int i = 0; i < EXP_BITS_DEF; i++) begin
			if ((e >> i) & 1) begin
				acc = (acc * sq) % m;
			end
			sq = (sq * sq) % m;
		end
		return acc[POWER_W-1:0];
	endfunction

	function automatic logic [62:0] random_wide();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[62:0];
	endfunction

	function automatic logic [BASE_W-1:0] pick_base(input logic [MOD_W-1:0] modulus);
		longint unsigned m;
		m = modulus;
		case ($urandom_range(0, 9))
			0: begin
				return BASE_W'(m * longint'($urandom));
			end
			1: begin
				return BASE_W'($urandom_range(0, 3));
			end
			2: begin
				return BASE_W'(m - 1);
			end
			3: begin
				return BASE_W'(m + 1 + m * $urandom_range(0, 1000));
			end
			default: begin
				return random_wide();
			end
		endcase
	endfunction

	function automatic logic [EXP_W-1:0] pick_exponent();
		logic [EXP_W-1:0] one_bit;
		one_bit = EXP_W'(1);
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return EXP_W'(1);
			end
			2: begin
				return EXP_MAX;
			end
			3: begin
				return one_bit << $urandom_range(0, EXP_W - 1);
			end
			4: begin
				return EXP_W'($urandom_range(0, 20));
			end
			default: begin
				return random_wide();
			end
		endcase
	endfunction

	// Called at a rising edge; returns at the edge on which the beat is taken, with
	// tvalid still high so that a following call can present its beat straight away.
	task automatic send_power_item(input logic [BASE_W-1:0] base,
			input logic [EXP_W-1:0] exponent);
		int gap;
		gap = 0;
		if (idle_enable && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 5);
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, exponent, base};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		expected_power.push_back(predict_power(base, exponent, current_modulus));
		items_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_power.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [MOD_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		current_modulus = value;
		modulus_settings++;
	endtask

	task automatic send_random_items(input int count);
		repeat (count) begin
			send_power_item(pick_base(current_modulus), pick_exponent());
		end
	endtask

	task automatic test_reset_modulus();
		logic [EXP_W-1:0] top_bit;
		top_bit = '0;
		top_bit[EXP_W-1] = 1'b1;
		send_power_item('0, '0);
		send_power_item('0, EXP_MAX);
		send_power_item(BASE_W'(1), '0);
		send_power_item(BASE_W'(2), EXP_W'(10));
		send_power_item(BASE_MAX, EXP_MAX);
		send_power_item(BASE_W'(MOD_RESET), '0);
		send_power_item(BASE_W'(3 * MOD_RESET), EXP_MAX);
		send_power_item(BASE_W'(MOD_RESET + 1), EXP_MAX);
		send_power_item(BASE_W'(MOD_RESET - 1), EXP_W'(2));
		send_power_item(BASE_W'(MOD_RESET - 1), EXP_MAX);
		send_power_item(BASE_W'(7), top_bit);
		send_power_item(BASE_MAX, '0);
	endtask

	task automatic test_modulus_extremes();
		write_modulus(MOD_MAX);
		send_power_item(BASE_W'(MOD_MAX - 1), EXP_MAX);
		send_power_item(BASE_W'(MOD_MAX), EXP_W'(5));
		send_power_item(BASE_MAX, EXP_W'(1));
		send_power_item(BASE_W'(3), EXP_MAX);
		// Every base is a multiple of one, so the answer is always zero.
		write_modulus(MOD_W'(1));
		send_power_item('0, '0);
		send_power_item(BASE_W'(5), '0);
		send_power_item(BASE_MAX, EXP_MAX);
		write_modulus(MOD_W'(2));
		send_power_item(BASE_W'(3), EXP_MAX);
		send_power_item(BASE_W'(4), '0);
		// A zero modulus cannot reduce anything and yields zero.
		write_modulus('0);
		send_power_item('0, '0);
		send_power_item(BASE_W'(9), EXP_W'(3));
	endtask

	task automatic test_random_moduli();
		logic [MOD_W-1:0] moduli[5];
		moduli[0] = MOD_W'($urandom_range(2, 32'h7fff_ffff));
		moduli[1] = MOD_W'(3);
		moduli[2] = 31'h4000_0000;
		moduli[3] = MOD_MAX;
		moduli[4] = MOD_W'($urandom_range(1, 1000));
		foreach (moduli[i]) begin
			write_modulus(moduli[i]);
			send_random_items(44);
		end
	endtask

	task automatic test_output_stall();
		write_modulus(MOD_W'($urandom_range(2, 32'h7fff_ffff)));
		// The sink stays off long enough for the result register and the datapath to
		// fill, so that the input side has to stall.
		sink_hold_cycles = SINK_HOLD_CYCLES;
		send_random_items(10);
	endtask

	task automatic test_full_rate();
		write_modulus(MOD_RESET);
		idle_enable = 1'b0;
		send_random_items(40);
	endtask

	initial begin : result_sink
		int burst_left;
		burst_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold_cycles != 0) begin
				m_axis_tready <= 1'b0;
				sink_hold_cycles--;
			end else if (burst_left != 0) begin
				m_axis_tready <= 1'b0;
				burst_left--;
			end else if (idle_enable && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				burst_left = $urandom_range(1, 5) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Outputs are looked at on the falling edge, where they are settled for the next
	// rising edge at which the beat is taken.
	initial begin : power_checker
		logic [POWER_W-1:0] got, want;
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[POWER_W-1:0];
				results_checked++;
				if (expected_power.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("[%0t] unexpected result beat: power %0d", $realtime, got);
					end
				end else begin
					want = expected_power.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("[%0t] power mismatch: expected %0d, got %0d",
								$realtime, want, got);
						end
					end
				end
			end
		end
	end

	initial begin : watchdog
		#60_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : run_tests
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_modulus();
		test_modulus_extremes();
		test_random_moduli();
		test_output_stall();
		test_full_rate();
		drain_results();
		$display("Sent %0d items and checked %0d results over %0d modulus settings.",
			items_sent, results_checked, modulus_settings);
		$display("Covered zero, one, two and full-width moduli, %s",
			"an output stall, and a full-rate tail.");
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches in total", mismatch_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
